// ===== design/order_book_imbalance_monitor_macros.svh =====
// Assertion macros used by the checker file obim_checker.sv.
`ifndef ORDER_BOOK_IMBALANCE_MONITOR_MACROS_SVH
`define ORDER_BOOK_IMBALANCE_MONITOR_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define OBIM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("order book monitor check failed");

// Next-cycle implication, disabled while reset is held.
`define OBIM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("order book monitor check failed");

`endif

// ===== design/obim_pkg.sv =====
`default_nettype none
package obim_pkg;

  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 96;
  localparam logic [35:0] MASK36 = 36'hF_FFFF_FFFF;
  localparam logic [16:0] ONE_Q16 = 17'h1_0000;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_EMA_WEIGHT      = 2'd0;
  localparam logic [1:0] REG_VACUUM_FRACTION = 2'd1;
  localparam logic [1:0] REG_HOLD_FRACTION   = 2'd2;

  typedef struct packed {
    logic [1:0]  book;
    logic [2:0]  level;
    logic        last;
    logic [31:0] bid_price;
    logic [31:0] bid_qty;
    logic [31:0] ask_price;
    logic [31:0] ask_qty;
  } obim_item_t;

  typedef struct packed {
    logic [15:0] ema_weight;
    logic [15:0] vacuum_fraction;
    logic [15:0] hold_fraction;
  } obim_cfg_t;

  typedef struct packed {
    logic        full_book;
    logic        vacuum;
    logic [35:0] baseline;
    logic [35:0] depth_total;
    logic [15:0] imbalance;
    logic [1:0]  book_id;
  } obim_res_t;

endpackage
`default_nettype wire

// ===== design/obim_front.sv =====
`default_nettype none
module obim_front import obim_pkg::*; #(
  parameter int LEVELS = 5,
  parameter int BOOKS  = 3
) (
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_DATA_W-1:0] in_tdata,
  input  wire logic                 q_full,
  output logic                      q_push,
  output obim_item_t                q_item
);

  logic in_range;

  // Items for an unknown book or a level outside the book are dropped here.
  always_comb begin
    q_item.book      = in_tdata[1:0];
    q_item.level     = in_tdata[4:2];
    q_item.bid_price = in_tdata[36:5];
    q_item.bid_qty   = in_tdata[68:37];
    q_item.ask_price = in_tdata[100:69];
    q_item.ask_qty   = in_tdata[132:101];
    q_item.last      = (int'(in_tdata[4:2]) == LEVELS - 1);
    in_range = (int'(in_tdata[1:0]) < BOOKS) && (int'(in_tdata[4:2]) < LEVELS);
  end

  assign in_tready = !q_full && rst_n;
  assign q_push    = in_tvalid && in_tready && in_range;

endmodule
`default_nettype wire

// ===== design/obim_fifo.sv =====
`default_nettype none
module obim_fifo import obim_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire obim_item_t  push_item,
  output logic             full,
  input  wire logic        pop,
  output logic             head_valid,
  output obim_item_t       head_item
);

  obim_item_t slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_item  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        slot_r[wr_ptr_r] <= push_item;
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

// ===== design/obim_back.sv =====
`default_nettype none
module obim_back import obim_pkg::*; #(
  parameter int LEVELS = 5,
  parameter int BOOKS  = 3
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire obim_cfg_t             cfg,
  input  wire logic                  q_valid,
  input  wire obim_item_t            q_item,
  output logic                       q_pop,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  localparam int SUM_W = 32 + $clog2(LEVELS + 1);
  localparam int DEP_W = (SUM_W + 1 > 36) ? SUM_W + 1 : 36;
  localparam int ENT   = BOOKS * LEVELS;
  localparam int IDX_W = (ENT > 1) ? $clog2(ENT) : 1;
  localparam int LC_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int VC_W  = $clog2(LEVELS + 1);
  localparam int BK_W  = (BOOKS > 1) ? $clog2(BOOKS) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_SUM, S_CALC, S_MULV, S_MULH, S_MULA, S_MULB, S_DIVI, S_DIV, S_EMIT
  } state_t;

  state_t      state_r;
  logic [31:0] bid_price_r [ENT];
  logic [31:0] bid_qty_r   [ENT];
  logic [31:0] ask_price_r [ENT];
  logic [31:0] ask_qty_r   [ENT];
  logic [51:0] baseline_r  [BOOKS];

  logic [1:0]       book_r;
  logic [IDX_W-1:0] base_r;
  logic [LC_W-1:0]  lvl_cnt_r;
  logic [SUM_W-1:0] bsum_r;
  logic [SUM_W-1:0] asum_r;
  logic [VC_W-1:0]  vcnt_r;
  logic [51:0]      old_r;
  logic [52:0]      thr_r;
  logic [52:0]      prod_r;
  logic             vac_r;
  logic             neg_r;
  logic             bit0_r;
  logic [DEP_W-1:0] rem_r;
  logic [15:0]      quo_r;
  logic [3:0]       div_cnt_r;
  logic [15:0]      imb_r;
  logic             out_valid_r;
  obim_res_t        out_r;

  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] rd_idx;
  logic [DEP_W-1:0] depth;
  logic [35:0]      dsat;
  logic [51:0]      dq;
  logic             full;
  logic [51:0]      mul_x;
  logic [16:0]      mul_f;
  logic [52:0]      mul_hi;
  logic [32:0]      mul_lo;
  logic [52:0]      prod;
  logic [52:0]      upd_sum;
  logic [SUM_W-1:0] diff;
  logic [DEP_W:0]   rem_sh;
  logic [DEP_W:0]   rem_sub;
  logic [BK_W-1:0]  bk;

  always_comb begin
    wr_idx  = IDX_W'(int'(q_item.book) * LEVELS + int'(q_item.level));
    rd_idx  = base_r + IDX_W'(lvl_cnt_r);
    bk      = book_r[BK_W-1:0];
    depth   = DEP_W'(bsum_r) + DEP_W'(asum_r);
    dsat    = (depth > DEP_W'(MASK36)) ? MASK36 : depth[35:0];
    dq      = {dsat, 16'h0000};
    full    = (int'(vcnt_r) == LEVELS);
    diff    = (asum_r > bsum_r) ? asum_r - bsum_r : bsum_r - asum_r;
    // One shared scaler with a Q1.16 factor: trunc(x * f / 65536).
    mul_x = old_r;
    mul_f = {1'b0, cfg.vacuum_fraction};
    case (state_r)
      S_MULH: mul_f = {1'b0, cfg.hold_fraction};
      S_MULA: begin
        mul_x = dq;
        mul_f = {1'b0, cfg.ema_weight};
      end
      S_MULB: mul_f = ONE_Q16 - {1'b0, cfg.ema_weight};
      default: ;
    endcase
    mul_hi  = 53'(mul_x[51:16]) * 53'(mul_f);
    mul_lo  = 33'(mul_x[15:0]) * 33'(mul_f);
    prod    = mul_hi + 53'(mul_lo[32:16]);
    upd_sum = prod_r + prod;
    // One restoring step of the quotient.
    rem_sh  = {rem_r, (div_cnt_r == 4'd0) ? bit0_r : 1'b0};
    rem_sub = rem_sh - {1'b0, depth};
  end

  assign q_pop      = (state_r == S_IDLE) && q_valid;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      bsum_r      <= '0;
      asum_r      <= '0;
      vcnt_r      <= '0;
      for (int i = 0; i < ENT; i++) begin
        bid_price_r[i] <= '0;
        bid_qty_r[i]   <= '0;
        ask_price_r[i] <= '0;
        ask_qty_r[i]   <= '0;
      end
      for (int b = 0; b < BOOKS; b++) begin
        baseline_r[b] <= '0;
      end
    end else begin
      // The emit state loads the register itself when it is taken.
      if (out_valid_r && out_tready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            if (q_item.bid_price != 32'd0) begin
              bid_price_r[wr_idx] <= q_item.bid_price;
              bid_qty_r[wr_idx]   <= q_item.bid_qty;
            end
            if (q_item.ask_price != 32'd0) begin
              ask_price_r[wr_idx] <= q_item.ask_price;
              ask_qty_r[wr_idx]   <= q_item.ask_qty;
            end
            if (q_item.last) begin
              book_r    <= q_item.book;
              base_r    <= IDX_W'(int'(q_item.book) * LEVELS);
              lvl_cnt_r <= '0;
              bsum_r    <= '0;
              asum_r    <= '0;
              vcnt_r    <= '0;
              vac_r     <= 1'b0;
              state_r   <= S_SUM;
            end
          end
        end
        S_SUM: begin
          bsum_r <= bsum_r + SUM_W'(bid_qty_r[rd_idx]);
          asum_r <= asum_r + SUM_W'(ask_qty_r[rd_idx]);
          if (bid_price_r[rd_idx] != 32'd0 && ask_price_r[rd_idx] != 32'd0) begin
            vcnt_r <= vcnt_r + VC_W'(1);
          end
          lvl_cnt_r <= lvl_cnt_r + LC_W'(1);
          if (int'(lvl_cnt_r) == LEVELS - 1) begin
            state_r <= S_CALC;
          end
        end
        S_CALC: begin
          old_r <= baseline_r[bk];
          if (!full) begin
            state_r <= S_DIVI;
          end else if (baseline_r[bk] == 52'd0) begin
            baseline_r[bk] <= dq;
            state_r <= S_DIVI;
          end else begin
            state_r <= S_MULV;
          end
        end
        S_MULV: begin
          thr_r   <= prod;
          state_r <= S_MULH;
        end
        S_MULH: begin
          vac_r   <= ({1'b0, dq} < thr_r);
          state_r <= ({1'b0, dq} > prod) ? S_MULA : S_DIVI;
        end
        S_MULA: begin
          prod_r  <= prod;
          state_r <= S_MULB;
        end
        S_MULB: begin
          baseline_r[bk] <= upd_sum[51:0];
          state_r <= S_DIVI;
        end
        S_DIVI: begin
          neg_r     <= (asum_r > bsum_r);
          rem_r     <= DEP_W'(diff >> 1);
          bit0_r    <= diff[0];
          quo_r     <= '0;
          div_cnt_r <= '0;
          if (depth == '0) begin
            imb_r   <= '0;
            state_r <= S_EMIT;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (!rem_sub[DEP_W]) begin
            rem_r <= rem_sub[DEP_W-1:0];
            quo_r <= {quo_r[14:0], 1'b1};
          end else begin
            rem_r <= rem_sh[DEP_W-1:0];
            quo_r <= {quo_r[14:0], 1'b0};
          end
          div_cnt_r <= div_cnt_r + 4'd1;
          if (div_cnt_r == 4'd15) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r       <= 1'b1;
            out_r.book_id     <= book_r;
            out_r.depth_total <= depth[35:0];
            out_r.baseline    <= baseline_r[bk][51:16];
            out_r.vacuum      <= vac_r;
            out_r.full_book   <= full;
            if (depth == '0) begin
              out_r.imbalance <= imb_r;
            end else if (neg_r) begin
              out_r.imbalance <= 16'd0 - quo_r;
            end else begin
              out_r.imbalance <= quo_r[15] ? 16'h7FFF : quo_r;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/order_book_imbalance_monitor.sv =====
`default_nettype none
// Channel   Dir  Width  Contents (lowest bit first)
// in_       in   136    book_select, level, bid_price, bid_qty, ask_price, ask_qty
// out_      out  96     book_id, imbalance, depth_total, baseline, vacuum, full_book
// cfg_      in   2+16   register index, write data
//
// A level word that does not end an update is stored by the back end, which stays idle.
// For the last level the back end stores the word, sums the book level by level, picks
// the baseline path, makes up to four passes through the shared Q1.16 scaler, sets up
// the divider, runs it for the sixteen quotient bits and loads the output register.
// Zero depth skips the divider. A two-word queue lets the front keep taking words while
// the back end works; the output register holds a result until it is taken, and the
// back end waits for it. Reset is synchronous, active low, and clears all stores at once.
module order_book_imbalance_monitor import obim_pkg::*; #(
  parameter int LEVELS = 5,
  parameter int BOOKS  = 3
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // book_select[1:0], level[4:2], bid_price[36:5], bid_qty[68:37],
  // ask_price[100:69], ask_qty[132:101], zero pad above
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // book_id[1:0], imbalance[17:2], depth_total[53:18], baseline[89:54],
  // vacuum[90], full_book[91], zero pad above
  output logic [OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                  cfg_wr_en,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [15:0]           cfg_wdata
);

  obim_cfg_t  cfg_r;
  obim_item_t push_item;
  obim_item_t head_item;
  logic       q_full;
  logic       q_push;
  logic       q_pop;
  logic       head_valid;

  // Configuration registers; writes to an unused index are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ema_weight      <= 16'd655;
      cfg_r.vacuum_fraction <= 16'd3277;
      cfg_r.hold_fraction   <= 16'd6554;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_EMA_WEIGHT:      cfg_r.ema_weight      <= cfg_wdata;
        REG_VACUUM_FRACTION: cfg_r.vacuum_fraction <= cfg_wdata;
        REG_HOLD_FRACTION:   cfg_r.hold_fraction   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  obim_front #(.LEVELS(LEVELS), .BOOKS(BOOKS)) u_front (
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  obim_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  obim_back #(.LEVELS(LEVELS), .BOOKS(BOOKS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (head_valid),
    .q_item     (head_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

// ===== design/obim_checker.sv =====
`default_nettype none
`include "order_book_imbalance_monitor_macros.svh"
module obim_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [95:0] out_tdata
);

  logic        stall;
  logic [15:0] out_imb;
  logic [35:0] out_depth;
  logic        out_vac;
  logic        out_full;
  logic [1:0]  out_book;

  assign stall     = out_tvalid && !out_tready;
  assign out_book  = out_tdata[1:0];
  assign out_imb   = out_tdata[17:2];
  assign out_depth = out_tdata[53:18];
  assign out_vac   = out_tdata[90];
  assign out_full  = out_tdata[91];

  // A stalled result keeps its word.
  `OBIM_ASSERT_NEXT(a_out_hold, clk, rst_n, stall, out_tvalid && $stable(out_tdata))
  // An empty book reports zero imbalance.
  `OBIM_ASSERT_NOW(a_empty_imb, clk, rst_n, out_tvalid && out_depth == 36'd0, out_imb == 16'd0)
  // Vacuum is only judged on a full book.
  `OBIM_ASSERT_NOW(a_vac_full, clk, rst_n, out_tvalid && out_vac, out_full)
  // Only the three known books ever report.
  `OBIM_ASSERT_NOW(a_book_id, clk, rst_n, out_tvalid, out_book != 2'd3)

endmodule

bind order_book_imbalance_monitor obim_checker u_obim_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

// ===== dv/order_book_imbalance_monitor_tb.sv =====
`timescale 1ns / 1ps
module order_book_imbalance_monitor_tb;
  import obim_pkg::*;

  localparam int LEVELS = 5;
  localparam int BOOKS  = 3;
  localparam int LIMIT_CYCLES = 400000;
  // Settle time after the last result.
  localparam int DRAIN_CYCLES = 80;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_wr_en = 1'b0;
  logic [1:0] cfg_index = REG_EMA_WEIGHT;
  logic [15:0] cfg_wdata = '0;

  always #1 clk = ~clk;

  order_book_imbalance_monitor dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // One level word as it enters the block.
  typedef struct {
    logic [1:0]  book;
    logic [2:0]  lvl;
    logic [31:0] bid_price;
    logic [31:0] bid_qty;
    logic [31:0] ask_price;
    logic [31:0] ask_qty;
  } level_word_t;

  // One book summary as it leaves the block.
  typedef struct {
    logic [1:0]  book_id;
    logic [15:0] imbalance;
    logic [35:0] depth_total;
    logic [35:0] baseline;
    logic        vacuum;
    logic        full_book;
  } book_summary_t;

  // Shadow copy of the book state and registers.
  logic [31:0] shadow_bid_px  [BOOKS*LEVELS];
  logic [31:0] shadow_bid_qty [BOOKS*LEVELS];
  logic [31:0] shadow_ask_px  [BOOKS*LEVELS];
  logic [31:0] shadow_ask_qty [BOOKS*LEVELS];
  logic [51:0] shadow_baseline [BOOKS];
  logic [15:0] shadow_weight, shadow_vac_frac, shadow_hold_frac;

  book_summary_t pending_summaries[$];
  // Hand-written expectations for directed rows, keyed by row.
  book_summary_t typed_expect[int];
  int errors = 0;
  int cycle_count = 0;
  bit quiet_tail = 0;

  // trunc(x * f / 65536) split so no bits are lost.
  function automatic logic [63:0] q16_scale(logic [63:0] x, logic [63:0] f);
    return (x >> 16) * f + (((x & 64'hFFFF) * f) >> 16);
  endfunction

  // Applies one level word to the shadow book; returns 1 with a summary when the
  // word closes the update.
  function automatic bit apply_level(level_word_t w, output book_summary_t s);
    int base;
    int full_cnt;
    logic [63:0] bsum, asum, depth, dq, old, diff, mag;
    bit full, vac, neg;
    s = '{default: '0};
    if (w.book >= BOOKS || w.lvl >= LEVELS) return 0;
    base = w.book * LEVELS;
    if (w.bid_price != 0) begin
      shadow_bid_px[base + w.lvl] = w.bid_price;
      shadow_bid_qty[base + w.lvl] = w.bid_qty;
    end
    if (w.ask_price != 0) begin
      shadow_ask_px[base + w.lvl] = w.ask_price;
      shadow_ask_qty[base + w.lvl] = w.ask_qty;
    end
    if (w.lvl != LEVELS - 1) return 0;
    bsum = 0; asum = 0; full_cnt = 0;
    for (int i = 0; i < LEVELS; i++) begin
      bsum += shadow_bid_qty[base + i];
      asum += shadow_ask_qty[base + i];
      if (shadow_bid_px[base + i] != 0 && shadow_ask_px[base + i] != 0) full_cnt++;
    end
    depth = bsum + asum;
    full = (full_cnt == LEVELS);
    vac = 0;
    if (full) begin
      dq = ((depth > 64'hF_FFFF_FFFF) ? 64'hF_FFFF_FFFF : depth) << 16;
      old = shadow_baseline[w.book];
      if (old == 0) begin
        shadow_baseline[w.book] = dq[51:0];
      end else begin
        if (dq < q16_scale(old, shadow_vac_frac)) vac = 1;
        if (dq > q16_scale(old, shadow_hold_frac))
          shadow_baseline[w.book] = 52'(q16_scale(dq, shadow_weight) +
                                        q16_scale(old, 64'd65536 - shadow_weight));
      end
    end
    if (depth == 0) begin
      s.imbalance = 0;
    end else begin
      neg = asum > bsum;
      diff = neg ? asum - bsum : bsum - asum;
      mag = (diff << 15) / depth;
      if (neg) s.imbalance = 16'(64'h10000 - mag);
      else s.imbalance = (mag > 32767) ? 16'd32767 : mag[15:0];
    end
    s.book_id = w.book;
    s.depth_total = depth[35:0];
    s.baseline = shadow_baseline[w.book][51:16];
    s.vacuum = vac;
    s.full_book = full;
    return 1;
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_level(level_word_t w);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[1:0] = w.book; d[4:2] = w.lvl;
    d[36:5] = w.bid_price; d[68:37] = w.bid_qty;
    d[100:69] = w.ask_price; d[132:101] = w.ask_qty;
    return d;
  endfunction

  // Random stall bursts on the result side; none once the quiet tail starts.
  int out_hold = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!quiet_tail && out_hold == 0 && $urandom_range(0, 9) == 0) begin
      out_hold <= $urandom_range(1, 12);
      out_tready <= 1'b0;
    end else if (out_hold > 1) begin
      out_hold <= out_hold - 1;
    end else begin
      out_hold <= 0;
      out_tready <= 1'b1;
    end
  end

  // Result checker: every accepted word is matched against the oldest summary.
  always @(posedge clk) begin
    book_summary_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_summaries.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, out_tdata);
        errors++;
      end else begin
        e = pending_summaries.pop_front();
        if (out_tdata[1:0] !== e.book_id) begin
          $display("%0t: book_id exp %0d got %0d", $time, e.book_id, out_tdata[1:0]);
          errors++;
        end
        if (out_tdata[17:2] !== e.imbalance) begin
          $display("%0t: imbalance exp %h got %h", $time, e.imbalance, out_tdata[17:2]);
          errors++;
        end
        if (out_tdata[53:18] !== e.depth_total) begin
          $display("%0t: depth_total exp %h got %h", $time, e.depth_total,
                   out_tdata[53:18]);
          errors++;
        end
        if (out_tdata[89:54] !== e.baseline) begin
          $display("%0t: baseline exp %h got %h", $time, e.baseline, out_tdata[89:54]);
          errors++;
        end
        if (out_tdata[90] !== e.vacuum) begin
          $display("%0t: vacuum exp %b got %b", $time, e.vacuum, out_tdata[90]);
          errors++;
        end
        if (out_tdata[91] !== e.full_book) begin
          $display("%0t: full_book exp %b got %b", $time, e.full_book, out_tdata[91]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // Sends one level word, with a random gap in front unless the tail is quiet.
  // Valid stays high after the handshake so words can follow back to back.
  task automatic send_level(level_word_t w, int row = -1);
    book_summary_t s;
    int gap;
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata <= pack_level(w);
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (apply_level(w, s)) begin
      if (typed_expect.exists(row)) s = typed_expect[row];
      pending_summaries.push_back(s);
    end
  endtask

  // Leaves the enable high so writes can follow each other; the caller drops it.
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_wr_en <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_EMA_WEIGHT:      shadow_weight = val;
      REG_VACUUM_FRACTION: shadow_vac_frac = val;
      REG_HOLD_FRACTION:   shadow_hold_frac = val;
      default: ;
    endcase
  endtask

  // Drain outstanding results before touching a register.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_summaries.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_qty();
    case ($urandom_range(0, 4))
      0: return 32'hFFFF_FFFF;
      1: return 0;
      2: return $urandom_range(0, 100);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_price();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom | 32'h1;
    endcase
  endfunction

  // Random content for one level; most sides supplied so books fill up.
  function automatic level_word_t rand_level(logic [1:0] book, logic [2:0] lvl);
    level_word_t w;
    w.book = book; w.lvl = lvl;
    w.bid_price = ($urandom_range(0, 7) == 0) ? 32'd0 : rand_price() | 32'h1;
    w.ask_price = ($urandom_range(0, 7) == 0) ? 32'd0 : rand_price() | 32'h1;
    w.bid_qty = rand_qty();
    w.ask_qty = rand_qty();
    return w;
  endfunction

  // Directed table: book, level, bid px, bid qty, ask px, ask qty.
  level_word_t directed_rows[] = '{
    // Empty book: only the last level, nothing supplied; zero depth, not full.
    '{2'd0, 3'd4, 32'd0, 32'd5, 32'd0, 32'd7},
    // Partial book of bids only; imbalance saturates at the top.
    '{2'd1, 3'd4, 32'd100, 32'd10, 32'd0, 32'd0},
    // Unknown book and level beyond the book are ignored.
    '{2'd3, 3'd4, 32'd1, 32'd1, 32'd1, 32'd1},
    '{2'd0, 3'd7, 32'd1, 32'd1, 32'd1, 32'd1},
    '{2'd0, 3'd5, 32'd1, 32'd1, 32'd1, 32'd1},
    // Full book at maximum quantities seeds the baseline.
    '{2'd2, 3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
    '{2'd2, 3'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
    '{2'd2, 3'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
    '{2'd2, 3'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
    '{2'd2, 3'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
    // Asks only dominate on book 0 (full book, negative imbalance).
    '{2'd0, 3'd0, 32'd9, 32'd0, 32'd10, 32'd1000},
    '{2'd0, 3'd1, 32'd9, 32'd0, 32'd11, 32'd1000},
    '{2'd0, 3'd2, 32'd9, 32'd0, 32'd12, 32'd1000},
    '{2'd0, 3'd3, 32'd9, 32'd0, 32'd13, 32'd1000},
    '{2'd0, 3'd4, 32'd9, 32'd0, 32'd14, 32'd1000},
    // Depth falls on book 0 but stays above the vacuum threshold; zero prices keep old levels.
    '{2'd0, 3'd0, 32'd9, 32'd0, 32'd10, 32'd0},
    '{2'd0, 3'd1, 32'd9, 32'd0, 32'd11, 32'd0},
    '{2'd0, 3'd2, 32'd9, 32'd0, 32'd12, 32'd0},
    '{2'd0, 3'd3, 32'd9, 32'd0, 32'd13, 32'd0},
    '{2'd0, 3'd4, 32'd9, 32'd1, 32'd0, 32'd55}
  };

  // Register settings visited between phases, extremes included.
  logic [15:0] phase_weight[] = '{16'd655, 16'd65535, 16'd1, 16'd0, 16'd30000};
  logic [15:0] phase_vac[]    = '{16'd3277, 16'd65535, 16'd0, 16'd40000, 16'd20000};
  logic [15:0] phase_hold[]   = '{16'd6554, 16'd0, 16'd65535, 16'd1000, 16'd50000};

  initial begin
    level_word_t w;
    logic [1:0] bk;
    for (int i = 0; i < BOOKS*LEVELS; i++) begin
      shadow_bid_px[i] = 0; shadow_bid_qty[i] = 0;
      shadow_ask_px[i] = 0; shadow_ask_qty[i] = 0;
    end
    for (int b = 0; b < BOOKS; b++) shadow_baseline[b] = 0;
    shadow_weight = 16'd655; shadow_vac_frac = 16'd3277; shadow_hold_frac = 16'd6554;

    // The empty book reports all zeros: no depth, no imbalance, not full.
    typed_expect[0] = '{2'd0, 16'd0, 36'd0, 36'd0, 1'b0, 1'b0};
    // Bids only: top of the imbalance range, not full, no baseline.
    typed_expect[1] = '{2'd1, 16'h7FFF, 36'd10, 36'd0, 1'b0, 1'b0};
    // All-max full book: balanced, and the baseline is seeded with the depth.
    typed_expect[9] = '{2'd2, 16'd0, 36'd42949672950, 36'd42949672950, 1'b0, 1'b1};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, run at reset register values.
    foreach (directed_rows[r]) send_level(directed_rows[r], r);
    wait_idle();

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_EMA_WEIGHT, phase_weight[ph]);
      write_reg(REG_VACUUM_FRACTION, phase_vac[ph]);
      write_reg(REG_HOLD_FRACTION, phase_hold[ph]);
      cfg_wr_en <= 1'b0;
      for (int n = 0; n < 26; n++) begin
        bk = $urandom_range(0, BOOKS - 1);
        if ($urandom_range(0, 9) == 0) begin
          // Noise: random word, possibly ignored or mid-update.
          w.book = $urandom; w.lvl = $urandom;
          w.bid_price = rand_price(); w.bid_qty = $urandom;
          w.ask_price = rand_price(); w.ask_qty = $urandom;
          send_level(w);
        end else begin
          // Well-formed update; sometimes broken off early.
          for (int l = 0; l < LEVELS; l++) begin
            if (l < LEVELS - 1 && $urandom_range(0, 29) == 0) break;
            w = rand_level(bk, l);
            // Shrinking or small quantities exercise vacuum and hold paths.
            if ($urandom_range(0, 3) == 0) begin
              w.bid_qty = w.bid_qty >> $urandom_range(0, 31);
              w.ask_qty = w.ask_qty >> $urandom_range(0, 31);
            end
            send_level(w);
          end
        end
        if (ph == 4 && n >= 18) quiet_tail = 1;
      end
      wait_idle();
    end

    if (errors == 0 && pending_summaries.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/obim_pkg.sv
design/obim_front.sv
design/obim_fifo.sv
design/obim_back.sv
design/order_book_imbalance_monitor.sv
design/obim_checker.sv
dv/order_book_imbalance_monitor_tb.sv
